/* rtl/strq_pkg.sv */
// Package for the sorted triple range query block: field widths, codes and shared types.
package strq_pkg;

  // Fixed widths of the stream fields
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned KEY_PORT_W = 16;
  localparam int unsigned SYL_PORT_W = 5;
  localparam int unsigned BOUND_W    = 6;
  localparam int unsigned CNT_W      = 13;
  // Syllable width used for compares: wide enough for any stored count and any bound
  localparam int unsigned CMP_SYL_W  = 8;

  // Default parameter values
  localparam int unsigned DEF_TABLE_DEPTH = 4096;
  localparam int unsigned DEF_KEY_BITS    = 16;
  localparam int unsigned DEF_SYL_BITS    = 5;

  // Slave-side tdata layout, lowest bit first
  localparam int unsigned S_IDX_LSB  = 0;
  localparam int unsigned S_K1_LSB   = S_IDX_LSB + IDX_W;
  localparam int unsigned S_K2_LSB   = S_K1_LSB + KEY_PORT_W;
  localparam int unsigned S_SYL_LSB  = S_K2_LSB + KEY_PORT_W;
  localparam int unsigned S_MIN_LSB  = S_SYL_LSB + SYL_PORT_W;
  localparam int unsigned S_MAX_LSB  = S_MIN_LSB + BOUND_W;
  localparam int unsigned S_USED_W   = S_MAX_LSB + BOUND_W;
  localparam int unsigned S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

  // Master-side tdata layout, lowest bit first
  localparam int unsigned M_FOUND_LSB = 0;
  localparam int unsigned M_FIRST_LSB = 1;
  localparam int unsigned M_LAST_LSB  = M_FIRST_LSB + IDX_W;
  localparam int unsigned M_USED_W    = M_LAST_LSB + IDX_W;
  localparam int unsigned M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } srch_stat_t;

endpackage

/* rtl/strq_store.sv */
// Entry store: one write port, one read port with registered read data.
module strq_store #(
  parameter int unsigned TABLE_DEPTH = strq_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned ENTRY_W     = 2 * strq_pkg::DEF_KEY_BITS + strq_pkg::DEF_SYL_BITS,
  localparam int unsigned AW         = $clog2(TABLE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [ENTRY_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [ENTRY_W-1:0] rd_data_o
);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/strq_search.sv */
// Search sequencer: a lower-bound then an upper-bound binary search over the entry store per query.
module strq_search #(
  parameter int unsigned TABLE_DEPTH = strq_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS    = strq_pkg::DEF_KEY_BITS,
  parameter int unsigned SYL_BITS    = strq_pkg::DEF_SYL_BITS,
  localparam int unsigned AW         = $clog2(TABLE_DEPTH),
  localparam int unsigned EW         = 2 * KEY_BITS + SYL_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [KEY_BITS-1:0]                  key_first_i,
  input  logic [KEY_BITS-1:0]                  key_second_i,
  input  logic signed [strq_pkg::BOUND_W-1:0]  min_syl_i,
  input  logic signed [strq_pkg::BOUND_W-1:0]  max_syl_i,
  input  logic [strq_pkg::CNT_W-1:0]           entry_count_i,
  input  logic                                 take_i,
  output strq_pkg::srch_stat_t                 stat_o,
  output strq_pkg::result_t                    res_o,
  output logic                                 rd_en_o,
  output logic [AW-1:0]                        rd_addr_o,
  input  logic [EW-1:0]                        rd_data_i
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = strq_pkg::CMP_SYL_W;
  localparam int unsigned IW = strq_pkg::IDX_W;
  localparam logic [SW-1:0] SylMax = SW'((1 << SYL_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } srch_state_e;

  srch_state_e state_q, state_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, n_q, n_d, first_q, first_d;
  logic upper_q, upper_d;
  logic [KEY_BITS-1:0] tk1_q, tk2_q;
  logic [SW-1:0] tlo_q, thi_q;

  // Bounds of the query
  logic [SW-1:0] lo_bound, hi_bound, mx_val;
  logic          reject;

  always_comb begin
    lo_bound = min_syl_i[strq_pkg::BOUND_W-1] ? '0 :
               SW'(unsigned'(min_syl_i[strq_pkg::BOUND_W-2:0]));
    mx_val   = SW'(unsigned'(max_syl_i[strq_pkg::BOUND_W-2:0]));
    if (max_syl_i[strq_pkg::BOUND_W-1]) begin
      hi_bound = SylMax;
    end else if (mx_val > SylMax) begin
      hi_bound = SylMax;
    end else begin
      hi_bound = mx_val;
    end
    reject = !max_syl_i[strq_pkg::BOUND_W-1] && (lo_bound > hi_bound);
  end

  // Lexicographic compare of the fetched entry against the target
  logic [2*KEY_BITS+SW-1:0] ent_cmp, tgt_cmp;
  logic                     go_right;

  always_comb begin
    ent_cmp  = {rd_data_i[EW-1 -: KEY_BITS], rd_data_i[SYL_BITS +: KEY_BITS],
                SW'(rd_data_i[SYL_BITS-1:0])};
    tgt_cmp  = {tk1_q, tk2_q, upper_q ? thi_q : tlo_q};
    go_right = upper_q ? (ent_cmp <= tgt_cmp) : (ent_cmp < tgt_cmp);
  end

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    n_d     = n_q;
    first_d = first_q;
    upper_d = upper_q;
    rd_en_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d     = (32'(entry_count_i) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                            : CW'(entry_count_i);
          lo_d    = '0;
          hi_d    = n_d;
          first_d = '0;
          upper_d = 1'b0;
          if (reject) begin
            hi_d    = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (lo_q < hi_q) begin
          mid_d   = lo_q + ((hi_q - lo_q) >> 1);
          rd_en_o = 1'b1;
          state_d = S_CMP;
        end else if (!upper_q) begin
          // lower edge settled: restart for the upper edge
          first_d = lo_q;
          upper_d = 1'b1;
          lo_d    = '0;
          hi_d    = n_q;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CMP: begin
        if (go_right) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = S_RD;
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rd_addr_o = mid_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      first_q <= '0;
      upper_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      first_q <= first_d;
      upper_q <= upper_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    n_q   <= n_d;
    if (state_q == S_IDLE && start_i) begin
      tk1_q <= key_first_i;
      tk2_q <= key_second_i;
      tlo_q <= lo_bound;
      thi_q <= hi_bound;
    end
  end

  // Result: lo_q holds the end of the run once both searches are done
  logic              found;
  logic [CW-1:0]     last_pos;
  logic [CW+IW-1:0]  first_ext, last_ext;

  always_comb begin
    found     = first_q < lo_q;
    last_pos  = lo_q - CW'(1);
    first_ext = {{IW{1'b0}}, first_q};
    last_ext  = {{IW{1'b0}}, last_pos};
    res_o.found       = found;
    res_o.first_index = found ? first_ext[IW-1:0] : '0;
    res_o.last_index  = found ? last_ext[IW-1:0] : '0;
    stat_o.idle       = (state_q == S_IDLE);
    stat_o.done       = (state_q == S_DONE);
  end

  a_bounds_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_CMP) |-> lo_q <= hi_q)
    else $error("search window inverted");

  a_probe_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> (mid_q >= lo_q) && (mid_q < hi_q))
    else $error("probe outside search window");

  a_start_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q != S_IDLE)
    else $error("query start lost");

  a_window_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |=> (hi_q - lo_q) < $past(hi_q - lo_q))
    else $error("search window did not shrink");

endmodule

/* rtl/sorted_triple_range_query.sv */
// Top level of the sorted triple range query block: stream ports, count register, result slot.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready| tuser kind, tdata entry/query fields
//  m_axis    | out       | m_axis_tvalid/m_axis_tready| tdata found, first_index, last_index
//  cfg       | in        | cfg_we_i (no wait)         | cfg_wdata_i entry_count
//
// A write request lands in the entry store at the accepting edge. A query request runs
// two binary searches through the single read port of the store, each probe being a read,
// then a compare. Requests are taken one at a time; ready is high whenever the sequencer
// is idle, even while an earlier result still waits in the output register for the
// downstream side. Reset clears the count and the control; the entry store holds no reset
// value and needs no clearing pass.
module sorted_triple_range_query #(
  parameter int unsigned TABLE_DEPTH = strq_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS    = strq_pkg::DEF_KEY_BITS,
  parameter int unsigned SYL_BITS    = strq_pkg::DEF_SYL_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: entry_index[11:0], key_first[27:12], key_second[43:28], syllables[48:44],
  //        min_syl[54:49], max_syl[60:55], zero[63:61]
  input  logic [strq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: kind[0]
  input  logic                             s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: found[0], first_index[12:1], last_index[24:13], zero[31:25]
  output logic [strq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [strq_pkg::CNT_W-1:0]       cfg_wdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = 2 * KEY_BITS + SYL_BITS;
  localparam int unsigned KP = strq_pkg::KEY_PORT_W;
  localparam int unsigned SP = strq_pkg::SYL_PORT_W;
  localparam int unsigned IW = strq_pkg::IDX_W;

  // Unpack the request
  logic [IW-1:0]                        in_idx;
  logic [KP-1:0]                        in_k1, in_k2;
  logic [SP-1:0]                        in_syl;
  logic signed [strq_pkg::BOUND_W-1:0]  in_min, in_max;

  assign in_idx = s_axis_tdata[strq_pkg::S_IDX_LSB +: IW];
  assign in_k1  = s_axis_tdata[strq_pkg::S_K1_LSB +: KP];
  assign in_k2  = s_axis_tdata[strq_pkg::S_K2_LSB +: KP];
  assign in_syl = s_axis_tdata[strq_pkg::S_SYL_LSB +: SP];
  assign in_min = signed'(s_axis_tdata[strq_pkg::S_MIN_LSB +: strq_pkg::BOUND_W]);
  assign in_max = signed'(s_axis_tdata[strq_pkg::S_MAX_LSB +: strq_pkg::BOUND_W]);

  // Fit port fields to the stored widths: keep the low bits, zero above
  logic [KEY_BITS+KP-1:0]   k1_ext, k2_ext;
  logic [SYL_BITS+SP-1:0]   syl_ext;
  logic [AW+IW-1:0]         idx_ext;
  logic [KEY_BITS-1:0]      key1, key2;
  logic [SYL_BITS-1:0]      syl;

  assign k1_ext  = {{KEY_BITS{1'b0}}, in_k1};
  assign k2_ext  = {{KEY_BITS{1'b0}}, in_k2};
  assign syl_ext = {{SYL_BITS{1'b0}}, in_syl};
  assign idx_ext = {{AW{1'b0}}, in_idx};
  assign key1    = k1_ext[KEY_BITS-1:0];
  assign key2    = k2_ext[KEY_BITS-1:0];
  assign syl     = syl_ext[SYL_BITS-1:0];

  strq_pkg::srch_stat_t stat;
  strq_pkg::result_t    res;

  logic in_acc, wr_en, start, take;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  assign s_axis_tready = stat.idle;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  // drop writes beyond the table
  assign wr_en  = in_acc && (s_axis_tuser == strq_pkg::KIND_WRITE) &&
                  (32'(in_idx) < 32'(TABLE_DEPTH));
  assign start  = in_acc && (s_axis_tuser == strq_pkg::KIND_QUERY);

  // Entry count register
  logic [strq_pkg::CNT_W-1:0] entry_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  strq_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ENTRY_W     (EW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_ext[AW-1:0]),
    .wr_data_i ({key1, key2, syl}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  strq_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .SYL_BITS    (SYL_BITS)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .key_first_i   (key1),
    .key_second_i  (key2),
    .min_syl_i     (in_min),
    .max_syl_i     (in_max),
    .entry_count_i (entry_count_q),
    .take_i        (take),
    .stat_o        (stat),
    .res_o         (res),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data)
  );

  // Output register: advance a finished result when the slot is empty or draining
  logic              out_valid_q, out_valid_d;
  strq_pkg::result_t out_res_q;

  assign take = stat.done && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = strq_pkg::M_TDATA_W'({out_res_q.last_index,
                                               out_res_q.first_index,
                                               out_res_q.found});

endmodule
